// ===== sv/atf_pkg.sv =====
package atf_pkg;

  localparam int SampleBitsDef = 12;
  localparam int SumBits       = 21;
  localparam int SumExtBits    = SumBits + 1;
  localparam int ScaleBits     = 16;
  localparam int ProdBits      = SumBits + ScaleBits;
  localparam int QuotBits      = 14;
  localparam int RemBits       = 30;
  localparam int BcdBits       = 16;
  localparam int StepBits      = 4;
  localparam int AddrBits      = 4;
  localparam int DataBits      = 32;
  localparam int CountBits     = 8;
  localparam int CharBits      = 8;

  // product at or above 10000 * 100000 saturates the reading at 99.99
  localparam logic [ProdBits-1:0] SatProduct = ProdBits'(64'd1000000000);
  localparam logic [RemBits-1:0]  DivisorTop = RemBits'(64'd100000 << (QuotBits - 1));
  localparam logic [QuotBits-1:0] QuotMax    = QuotBits'(9999);

  localparam logic [StepBits-1:0] MulLast = StepBits'(ScaleBits - 1);
  localparam logic [StepBits-1:0] DivLast = StepBits'(QuotBits - 1);
  localparam logic [StepBits-1:0] BcdLast = StepBits'(QuotBits - 1);

  localparam logic [CountBits-1:0] SprReset   = 8'd100;
  localparam logic [ScaleBits-1:0] ScaleReset = 16'd2442;
  localparam logic [CharBits-1:0]  DegReset   = 8'hA7;

  localparam logic [CharBits-1:0] AsciiZero  = 8'h30;
  localparam logic [CharBits-1:0] AsciiPoint = 8'h2E;
  localparam logic [CharBits-1:0] AsciiC     = 8'h43;
  localparam logic [CharBits-1:0] AsciiCr    = 8'h0D;

  typedef enum logic [1:0] {
    REG_SPR   = 2'd0,
    REG_SCALE = 2'd1,
    REG_DEG   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               done;
    logic [BcdBits-1:0] digits;
  } conv_stat_t;

endpackage

// ===== sv/atf_conv.sv =====
module atf_conv (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [atf_pkg::SumBits-1:0]    sum_i,
  input  logic [atf_pkg::ScaleBits-1:0]  scale_i,
  output atf_pkg::conv_stat_t            stat_o
);

  typedef enum logic [4:0] {
    CV_IDLE  = 5'b00001,
    CV_MUL   = 5'b00010,
    CV_CHECK = 5'b00100,
    CV_DIV   = 5'b01000,
    CV_BCD   = 5'b10000
  } conv_state_e;

  conv_state_e state_q, state_d;
  logic [atf_pkg::StepBits-1:0]  cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [atf_pkg::ProdBits-1:0]  acc_q, acc_d;
  logic [atf_pkg::SumBits-1:0]   mcand_q, mcand_d;
  logic [atf_pkg::ScaleBits-1:0] mplier_q, mplier_d;
  logic [atf_pkg::RemBits-1:0]   dvs_q, dvs_d;
  logic [atf_pkg::QuotBits-1:0]  quot_q, quot_d;
  logic [atf_pkg::BcdBits-1:0]   bcd_q, bcd_d;
  logic [atf_pkg::BcdBits-1:0]   bcd_adj;
  logic [atf_pkg::RemBits-1:0]   rem;

  // add three to every decimal digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < atf_pkg::BcdBits / 4; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  assign rem = acc_q[atf_pkg::RemBits-1:0];

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    dvs_d    = dvs_q;
    quot_d   = quot_q;
    bcd_d    = bcd_q;
    case (state_q)
      CV_IDLE: begin
        if (start_i) begin
          acc_d    = '0;
          mcand_d  = sum_i;
          mplier_d = scale_i;
          cnt_d    = atf_pkg::MulLast;
          state_d  = CV_MUL;
        end
      end
      CV_MUL: begin
        // shift-add, multiplier bits taken most significant first
        acc_d = {acc_q[atf_pkg::ProdBits-2:0], 1'b0}
              + (mplier_q[atf_pkg::ScaleBits-1] ? atf_pkg::ProdBits'(mcand_q)
                                                 : {atf_pkg::ProdBits{1'b0}});
        mplier_d = {mplier_q[atf_pkg::ScaleBits-2:0], 1'b0};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = CV_CHECK;
        end
      end
      CV_CHECK: begin
        if (acc_q >= atf_pkg::SatProduct) begin
          quot_d  = atf_pkg::QuotMax;
          bcd_d   = '0;
          cnt_d   = atf_pkg::BcdLast;
          state_d = CV_BCD;
        end else begin
          quot_d  = '0;
          dvs_d   = atf_pkg::DivisorTop;
          cnt_d   = atf_pkg::DivLast;
          state_d = CV_DIV;
        end
      end
      CV_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem >= dvs_q) begin
          acc_d[atf_pkg::RemBits-1:0] = rem - dvs_q;
          quot_d = {quot_q[atf_pkg::QuotBits-2:0], 1'b1};
        end else begin
          quot_d = {quot_q[atf_pkg::QuotBits-2:0], 1'b0};
        end
        dvs_d = {1'b0, dvs_q[atf_pkg::RemBits-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          bcd_d   = '0;
          cnt_d   = atf_pkg::BcdLast;
          state_d = CV_BCD;
        end
      end
      CV_BCD: begin
        bcd_d  = {bcd_adj[atf_pkg::BcdBits-2:0], quot_q[atf_pkg::QuotBits-1]};
        quot_d = {quot_q[atf_pkg::QuotBits-2:0], 1'b0};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = CV_IDLE;
        end
      end
      default: begin
        state_d = CV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    dvs_q    <= dvs_d;
    quot_q   <= quot_d;
    bcd_q    <= bcd_d;
  end

  assign stat_o.done   = done_q;
  assign stat_o.digits = bcd_q;

endmodule

// ===== sv/averaged_temperature_ascii_formatter.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o  adc_sample_i
// out      output     out_valid_o / out_ready_i out_char_o, last_char_o
// cfg      input      APB psel/penable/pwrite  paddr, pwdata -> prdata
//
// A sample that does not complete a reading is added to the running sum and in_ready_o stays high.
// A completing sample runs the serial converter: 16 multiply steps, one
// saturation check, 14 division steps and 14 BCD shift steps; the division
// is skipped when the check saturates, and the first character is offered
// once the converter reports done.
// Eight characters then leave at one per cycle while out_ready_i is high.
// in_ready_o is low from a completing sample until the carriage return is taken.
// Reset clears the running sum, the count and loads the register defaults.
module averaged_temperature_ascii_formatter #(
  parameter int SampleBits = atf_pkg::SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [SampleBits-1:0]         adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [atf_pkg::CharBits-1:0]  out_char_o,
  output logic                          last_char_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [atf_pkg::AddrBits-1:0]  paddr,
  input  logic [atf_pkg::DataBits-1:0]  pwdata,
  output logic [atf_pkg::DataBits-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } top_state_e;

  typedef enum logic [2:0] {
    POS_TENS   = 3'd0,
    POS_UNITS  = 3'd1,
    POS_POINT  = 3'd2,
    POS_TENTHS = 3'd3,
    POS_HUNDS  = 3'd4,
    POS_DEG    = 3'd5,
    POS_C      = 3'd6,
    POS_CR     = 3'd7
  } line_pos_e;

  top_state_e state_q, state_d;
  line_pos_e  pos_q, pos_d;

  logic [atf_pkg::CountBits-1:0] spr_q;
  logic [atf_pkg::ScaleBits-1:0] scale_q;
  logic [atf_pkg::CharBits-1:0]  deg_q;
  logic [atf_pkg::SumBits-1:0]   sum_q, sum_d;
  logic [atf_pkg::CountBits-1:0] count_q, count_d;

  logic [atf_pkg::SumExtBits-1:0] sum_ext;
  logic [atf_pkg::SumBits-1:0]    sum_sat;
  logic [atf_pkg::CountBits-1:0]  limit;
  logic                           complete;
  logic                           in_acc;
  logic                           out_acc;
  logic                           cfg_wr;
  atf_pkg::conv_stat_t            stat;

  function automatic logic [atf_pkg::CharBits-1:0] line_char(
    line_pos_e                     p,
    logic [atf_pkg::BcdBits-1:0]   d,
    logic [atf_pkg::CharBits-1:0]  deg
  );
    logic [atf_pkg::CharBits-1:0] c;
    case (p)
      POS_TENS:   c = atf_pkg::AsciiZero + atf_pkg::CharBits'(d[15:12]);
      POS_UNITS:  c = atf_pkg::AsciiZero + atf_pkg::CharBits'(d[11:8]);
      POS_POINT:  c = atf_pkg::AsciiPoint;
      POS_TENTHS: c = atf_pkg::AsciiZero + atf_pkg::CharBits'(d[7:4]);
      POS_HUNDS:  c = atf_pkg::AsciiZero + atf_pkg::CharBits'(d[3:0]);
      POS_DEG:    c = deg;
      POS_C:      c = atf_pkg::AsciiC;
      POS_CR:     c = atf_pkg::AsciiCr;
      default:    c = atf_pkg::AsciiCr;
    endcase
    return c;
  endfunction

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_acc     = out_valid_o && out_ready_i;
  assign out_char_o  = line_char(pos_q, stat.digits, deg_q);
  assign last_char_o = (pos_q == POS_CR);

  // running sum saturates at its full width
  assign sum_ext  = {1'b0, sum_q} + atf_pkg::SumExtBits'(adc_sample_i);
  assign sum_sat  = sum_ext[atf_pkg::SumBits] ? {atf_pkg::SumBits{1'b1}}
                                              : sum_ext[atf_pkg::SumBits-1:0];
  assign limit    = (spr_q == '0) ? atf_pkg::CountBits'(1) : spr_q;
  assign complete = ({1'b0, count_q} + 9'd1) >= {1'b0, limit};

  atf_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && complete),
    .sum_i   (sum_sat),
    .scale_i (scale_q),
    .stat_o  (stat)
  );

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    sum_d   = sum_q;
    count_d = count_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (complete) begin
            sum_d   = '0;
            count_d = '0;
            state_d = ST_CONV;
          end else begin
            sum_d   = sum_sat;
            count_d = count_q + 1'b1;
          end
        end
      end
      ST_CONV: begin
        if (stat.done) begin
          pos_d   = POS_TENS;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (pos_q == POS_CR) begin
            state_d = ST_IDLE;
          end else begin
            pos_d = line_pos_e'(pos_q + 3'd1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= POS_TENS;
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q   <= atf_pkg::SprReset;
      scale_q <= atf_pkg::ScaleReset;
      deg_q   <= atf_pkg::DegReset;
    end else if (cfg_wr) begin
      case (atf_pkg::cfg_idx_e'(paddr[3:2]))
        atf_pkg::REG_SPR:   spr_q   <= pwdata[atf_pkg::CountBits-1:0];
        atf_pkg::REG_SCALE: scale_q <= pwdata[atf_pkg::ScaleBits-1:0];
        atf_pkg::REG_DEG:   deg_q   <= pwdata[atf_pkg::CharBits-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_comb begin
    case (atf_pkg::cfg_idx_e'(paddr[3:2]))
      atf_pkg::REG_SPR:   prdata = atf_pkg::DataBits'(spr_q);
      atf_pkg::REG_SCALE: prdata = atf_pkg::DataBits'(scale_q);
      atf_pkg::REG_DEG:   prdata = atf_pkg::DataBits'(deg_q);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== verif/atf_line_checker.sv =====
module atf_line_checker
  import atf_pkg::*;
#(
  parameter int SampleBits = SampleBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SampleBits-1:0] adc_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [CharBits-1:0]   out_char_i,
  input  logic                  last_char_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [AddrBits-1:0]   paddr_i,
  input  logic [DataBits-1:0]   pwdata_i,
  input  logic [DataBits-1:0]   prdata_i,
  input  logic                  pready_i,
  output int                    fail_count_o,
  output int                    chars_pending_o,
  output int                    lines_done_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] SumLimit      = (64'd1 << SumBits) - 64'd1;
  localparam logic [63:0] ScaleDivisor  = 64'd100000;
  localparam logic [63:0] HundredthsMax = 64'd9999;

  typedef struct packed {
    logic [CharBits-1:0] ch;
    logic                last;
  } char_beat_t;

  char_beat_t              line_chars_q[$];
  logic [SumBits-1:0]      run_sum;
  logic [CountBits-1:0]    run_count;
  logic [CountBits-1:0]    cfg_spr;
  logic [ScaleBits-1:0]    cfg_scale;
  logic [CharBits-1:0]     cfg_deg;

  initial begin
    fail_count_o    = 0;
    chars_pending_o = 0;
    lines_done_o    = 0;
  end

  task automatic flag_mismatch(input string msg);
    if (fail_count_o < 200) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    fail_count_o++;
  endtask

  // add one sample to the running sum; on the closing sample queue the text line
  task automatic accumulate_sample(input logic [SampleBits-1:0] sample);
    logic [63:0] total;
    logic [63:0] limit;
    logic [63:0] hundredths;
    total = 64'(run_sum) + 64'(sample);
    if (total > SumLimit) begin
      total = SumLimit;
    end
    limit = (cfg_spr == '0) ? 64'd1 : 64'(cfg_spr);
    if (64'(run_count) + 64'd1 < limit) begin
      run_sum   = SumBits'(total);
      run_count = run_count + 1'b1;
    end else begin
      hundredths = (total * 64'(cfg_scale)) / ScaleDivisor;
      if (hundredths > HundredthsMax) begin
        hundredths = HundredthsMax;
      end
      line_chars_q.push_back('{AsciiZero + CharBits'(hundredths / 1000), 1'b0});
      line_chars_q.push_back('{AsciiZero + CharBits'((hundredths % 1000) / 100), 1'b0});
      line_chars_q.push_back('{AsciiPoint, 1'b0});
      line_chars_q.push_back('{AsciiZero + CharBits'((hundredths % 100) / 10), 1'b0});
      line_chars_q.push_back('{AsciiZero + CharBits'(hundredths % 10), 1'b0});
      line_chars_q.push_back('{cfg_deg, 1'b0});
      line_chars_q.push_back('{AsciiC, 1'b0});
      line_chars_q.push_back('{AsciiCr, 1'b1});
      run_sum   = '0;
      run_count = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cfg_idx_e            reg_idx;
    logic [DataBits-1:0] reg_val;
    logic                reg_known;
    char_beat_t          exp_beat;
    if (!rst_ni) begin
      cfg_spr   = 8'd100;
      cfg_scale = 16'd2442;
      cfg_deg   = 8'hA7;
      run_sum   = '0;
      run_count = '0;
      line_chars_q.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[1:0] == 2'b00) begin
        reg_idx   = cfg_idx_e'(paddr_i[3:2]);
        reg_known = 1'b1;
        reg_val   = '0;
        case (reg_idx)
          REG_SPR: begin
            if (pwrite_i) cfg_spr = pwdata_i[CountBits-1:0];
            reg_val = DataBits'(cfg_spr);
          end
          REG_SCALE: begin
            if (pwrite_i) cfg_scale = pwdata_i[ScaleBits-1:0];
            reg_val = DataBits'(cfg_scale);
          end
          REG_DEG: begin
            if (pwrite_i) cfg_deg = pwdata_i[CharBits-1:0];
            reg_val = DataBits'(cfg_deg);
          end
          default: begin
            // unmapped address: write dropped, read value undefined
            reg_known = 1'b0;
          end
        endcase
        if (!pwrite_i && reg_known && prdata_i !== reg_val) begin
          flag_mismatch($sformatf("register read at 0x%0h gave 0x%0h, want 0x%0h",
                                  paddr_i, prdata_i, reg_val));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (line_chars_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected char 0x%02h last=%0b", out_char_i, last_char_i));
        end else begin
          exp_beat = line_chars_q.pop_front();
          if (out_char_i !== exp_beat.ch) begin
            flag_mismatch($sformatf("line %0d: char 0x%02h, want 0x%02h",
                                    lines_done_o, out_char_i, exp_beat.ch));
          end
          if (last_char_i !== exp_beat.last) begin
            flag_mismatch($sformatf("line %0d: last flag %0b, want %0b",
                                    lines_done_o, last_char_i, exp_beat.last));
          end
          if (exp_beat.last) begin
            lines_done_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        accumulate_sample(adc_sample_i);
      end
    end
    chars_pending_o = line_chars_q.size();
  end

endmodule

// ===== verif/averaged_temperature_ascii_formatter_test.sv =====
module averaged_temperature_ascii_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import atf_pkg::*;

  localparam int TotalItems   = 470;
  localparam int CycleLimit   = 1000000;
  localparam int SettleCycles = 64;
  localparam int HoldCycles   = 300;
  localparam logic [AddrBits-1:0] AddrUnmapped = AddrBits'(12);

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [SampleBitsDef-1:0] adc_sample;
  logic                     out_valid;
  logic                     out_ready;
  logic [CharBits-1:0]      out_char;
  logic                     last_char;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [AddrBits-1:0]      paddr;
  logic [DataBits-1:0]      pwdata;
  logic [DataBits-1:0]      prdata;
  logic                     pready;

  int fail_count;
  int chars_pending;
  int lines_done;
  int cycles;
  int samples_sent;
  int rx_hold_req;
  bit tx_steady;
  bit rx_steady;

  averaged_temperature_ascii_formatter i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .adc_sample_i (adc_sample),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_char_o   (out_char),
    .last_char_o  (last_char),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  atf_line_checker i_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .adc_sample_i    (adc_sample),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_char_i      (out_char),
    .last_char_i     (last_char),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_i        (prdata),
    .pready_i        (pready),
    .fail_count_o    (fail_count),
    .chars_pending_o (chars_pending),
    .lines_done_o    (lines_done)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("run stuck: %0d cycles, %0d chars still owed", cycles, chars_pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: random stalls, steady stretches, and long hold-offs on request
  initial begin : rx_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_steady || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [AddrBits-1:0] addr,
                            input logic [DataBits-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // leave the bus idle between transfers
    @(negedge clk);
  endtask

  // write, then read back so the checker sees the stored value
  task automatic set_reg(input cfg_idx_e r, input logic [DataBits-1:0] v);
    apb_access(1'b1, {r, 2'b00}, v);
    apb_access(1'b0, {r, 2'b00}, '0);
  endtask

  task automatic send_sample(input logic [SampleBitsDef-1:0] s);
    int gap;
    in_valid   <= 1'b1;
    adc_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
    if (tx_steady) begin
      gap = 0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1:          gap = $urandom_range(8, 40);
        2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
        default:       gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // drop valid, wait until every queued char has left, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [SampleBitsDef-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SampleBitsDef'($urandom_range(0, 15));
      default: return SampleBitsDef'($urandom());
    endcase
  endfunction

  initial begin : stim
    int                  phase;
    int                  per_reading;
    int                  n_items;
    logic [CountBits-1:0] spr_pick;
    logic [ScaleBits-1:0] scale_pick;
    logic [DataBits-1:0] noise;

    cycles       = 0;
    samples_sent = 0;
    rx_hold_req  = 0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    adc_sample   = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset values
    apb_access(1'b0, {REG_SPR, 2'b00}, '0);
    apb_access(1'b0, {REG_SCALE, 2'b00}, '0);
    apb_access(1'b0, {REG_DEG, 2'b00}, '0);

    // one sample per line: zero input and full-scale input at default scale
    set_reg(REG_SPR, 32'd1);
    send_sample('0);
    send_sample('1);
    drain_results();
    set_reg(REG_DEG, 32'h00);
    set_reg(REG_SCALE, 32'hFFFF);
    send_sample('1);
    send_sample(SampleBitsDef'(1));
    // reading past 99.99 clamps
    drain_results();
    set_reg(REG_DEG, 32'hFF);
    set_reg(REG_SPR, 32'd4);
    repeat (4) send_sample('1);
    // zero samples per reading behaves as one
    drain_results();
    set_reg(REG_SPR, 32'd0);
    send_sample(SampleBitsDef'(2048));
    send_sample(SampleBitsDef'(2730));
    drain_results();
    set_reg(REG_SCALE, 32'd0);
    send_sample('1);
    // lower the sample count mid-reading: next sample closes it
    drain_results();
    set_reg(REG_SCALE, 32'd2442);
    set_reg(REG_SPR, 32'd5);
    send_sample(SampleBitsDef'(100));
    send_sample(SampleBitsDef'(200));
    send_sample(SampleBitsDef'(300));
    drain_results();
    set_reg(REG_SPR, 32'd2);
    send_sample(SampleBitsDef'(400));
    // unmapped register: write dropped
    drain_results();
    apb_access(1'b1, AddrUnmapped, 32'hFFFF_FFFF);
    apb_access(1'b0, {REG_SPR, 2'b00}, '0);
    apb_access(1'b0, {REG_SCALE, 2'b00}, '0);
    apb_access(1'b0, {REG_DEG, 2'b00}, '0);
    send_sample(SampleBitsDef'(12'hAAA));
    send_sample(SampleBitsDef'(12'h555));

    phase = 0;
    while (samples_sent < TotalItems) begin
      phase++;
      drain_results();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        spr_pick = 8'd255;
      end else if (phase == 3) begin
        spr_pick = 8'd1;
      end else begin
        case ($urandom_range(0, 9))
          0:          spr_pick = '0;
          1, 2:       spr_pick = CountBits'($urandom_range(5, 12));
          default:    spr_pick = CountBits'($urandom_range(1, 4));
        endcase
      end
      noise = $urandom_range(0, 1) ? ($urandom() & 32'hFFFF_FF00) : '0;
      set_reg(REG_SPR, noise | DataBits'(spr_pick));
      if (phase == 1 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 7))
          0:       scale_pick = '0;
          1:       scale_pick = '1;
          2:       scale_pick = 16'd2442;
          default: scale_pick = ScaleBits'($urandom());
        endcase
        noise = $urandom_range(0, 1) ? ($urandom() & 32'hFFFF_0000) : '0;
        set_reg(REG_SCALE, noise | DataBits'(scale_pick));
      end
      if ($urandom_range(0, 1) == 1) begin
        set_reg(REG_DEG, $urandom());
      end

      if (phase == 3) begin
        // hold the output long while samples keep coming: the block backs up
        tx_steady   = 1'b1;
        rx_hold_req = HoldCycles;
        repeat (6) send_sample(pick_sample());
      end else begin
        per_reading = (spr_pick == '0) ? 1 : int'(spr_pick);
        if (phase == 1) begin
          n_items = per_reading;
        end else begin
          // leave a partial reading behind now and then for the next setting
          n_items = per_reading * $urandom_range(1, 4) + $urandom_range(0, per_reading - 1);
        end
        repeat (n_items) send_sample(pick_sample());
      end
    end

    drain_results();
    $display("%0d samples sent, %0d text lines checked over %0d random settings",
             samples_sent, lines_done, phase);
    $display("%0d mismatches, %0d chars never delivered", fail_count, chars_pending);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
